>>> rtl/multi_timer_event_scheduler_defines.svh
// Assertion helpers shared by the scheduler RTL.
// Both sample on the rising edge of clk and stay quiet while rst is high.
`ifndef MULTI_TIMER_EVENT_SCHEDULER_DEFINES_SVH
`define MULTI_TIMER_EVENT_SCHEDULER_DEFINES_SVH

// Check a condition at every edge.
`define MTS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequence holds in the cycle after an antecedent.
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mts_pkg.sv
`default_nettype none

package mts_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned KIND_W = 2;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd2;

  // Command beat.
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [TIME_W-1:0] interval_ticks;
    logic              periodic;
    logic [SLOT_W-1:0] handle;
  } cmd_t;

  // Event beat.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic              ok;
    logic              was_periodic;
    logic              last;
  } evt_t;

  // Command context broadcast to every cell for the item in flight.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] period;
    logic              periodic;
    logic [SLOT_W-1:0] handle;
  } bcast_t;

  // Handed from cell to cell: the visit token and whether a free slot was taken.
  typedef struct packed {
    logic tok;
    logic claimed;
  } link_t;

  // Result of one cell visit; all zero when the cell does not report.
  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic              ok;
    logic              was_periodic;
  } res_t;

  function automatic evt_t to_evt(res_t r, logic last);
    evt_t e;
    e.kind         = r.kind;
    e.slot         = r.slot;
    e.ok           = r.ok;
    e.was_periodic = r.was_periodic;
    e.last         = last;
    return e;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mts_cell.sv
`default_nettype none

module mts_cell import mts_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   adv,
  input  wire bcast_t bc,
  input  wire link_t  link_in,
  output link_t       link_out,
  output res_t        res
);

  localparam bit                IN_RANGE = IDX < (2 ** SLOT_W);
  localparam logic [SLOT_W-1:0] IDX_SLOT = SLOT_W'(IDX);

  logic              armed;
  logic              periodic;
  logic [TIME_W-1:0] period;
  logic [TIME_W-1:0] alarm;
  link_t             link_q;

  logic act, due, take, match, hit;

  assign act   = link_in.tok;
  assign due   = armed && (alarm == bc.now);
  assign take  = !armed && !link_in.claimed;
  assign match = IN_RANGE && (bc.handle == IDX_SLOT);

  always_comb begin
    hit = 1'b0;
    res = '0;
    unique case (bc.op)
      OP_TICK:   hit = due;
      OP_ADD:    hit = take;
      OP_CANCEL: hit = match;
      default:   hit = 1'b0;
    endcase
    if (act && hit) begin
      res.hit  = 1'b1;
      res.slot = IDX_SLOT;
      unique case (bc.op)
        OP_TICK: begin
          res.kind         = KIND_FIRED;
          res.ok           = 1'b1;
          res.was_periodic = periodic;
        end
        OP_ADD: begin
          res.kind = KIND_ADD;
          res.ok   = 1'b1;
        end
        default: begin
          res.kind = KIND_CANCEL;
          res.ok   = armed;
        end
      endcase
    end
  end

  // Slot state changes only on the visit.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed    <= 1'b0;
      periodic <= 1'b0;
    end else if (adv && act && hit) begin
      unique case (bc.op)
        OP_TICK: begin
          if (!periodic) begin
            armed <= 1'b0;
          end
        end
        OP_ADD: begin
          armed    <= 1'b1;
          periodic <= bc.periodic;
        end
        default: armed <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv && act && hit) begin
      if (bc.op == OP_TICK && periodic) begin
        alarm <= alarm + period;
      end else if (bc.op == OP_ADD) begin
        period <= bc.period;
        alarm  <= bc.now + bc.period;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_q <= '0;
    end else if (adv) begin
      link_q.tok     <= link_in.tok;
      link_q.claimed <= link_in.claimed || (act && bc.op == OP_ADD && take);
    end
  end

  assign link_out = link_q;

endmodule

`default_nettype wire

>>> rtl/multi_timer_event_scheduler.sv
`default_nettype none
// Channel  | handshake                  | beat
// ---------+----------------------------+-------------------------------------
// command  | cmd_valid / cmd_stall      | cmd (opcode, interval, periodic, handle)
// event    | evt_valid / evt_stall      | evt (kind, slot, ok, was_periodic, last)
//
// Each command is accepted, then the visit token walks the slot chain from
// cell to cell, then the walk closes out and flags the last event; a new
// command is taken only after the close-out.
// A stalled event register freezes the chain walk until it drains.
// rst clears time, armed flags and all handshake state.
// Period and alarm registers carry no reset; they are written on arming.

`include "multi_timer_event_scheduler_defines.svh"

module multi_timer_event_scheduler import mts_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  output logic      evt_valid,
  input  wire logic evt_stall,
  output evt_t      evt
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t            state;
  logic              launch;   // token waiting to enter cell 0
  bcast_t            bc;       // context of the command in flight
  logic [OP_W-1:0]   op;
  logic [TIME_W-1:0] period;
  logic              periodic;
  logic [SLOT_W-1:0] handle;
  logic [TIME_W-1:0] now;
  res_t              pend;     // newest cell report, held until we know if it is last
  logic              pend_valid;
  evt_t              evt_q;
  logic              evt_load;

  link_t             chain [NUM_SLOTS+1];
  res_t              res   [NUM_SLOTS];
  res_t              sel;
  logic [NUM_SLOTS:0] tok_vec;
  logic              adv;
  logic              end_tok;

  // Advance the walk only when the event register can take a beat.
  assign adv       = !evt_valid || !evt_stall;
  assign cmd_stall = (state != S_IDLE);
  assign evt       = evt_q;

  assign chain[0] = '{tok: launch, claimed: 1'b0};
  assign end_tok  = chain[NUM_SLOTS].tok;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    mts_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .bc       (bc),
      .link_in  (chain[i]),
      .link_out (chain[i+1]),
      .res      (res[i])
    );
  end

  // Only the cell holding the token reports, so OR the results together.
  always_comb begin
    sel = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      sel = sel | res[i];
    end
    for (int i = 0; i <= NUM_SLOTS; i++) begin
      tok_vec[i] = chain[i].tok;
    end
  end

  assign bc = '{op: op, now: now, period: period, periodic: periodic, handle: handle};

  // Load the event register when a newer firing shows the held one is not
  // last, or when the walk closes with a beat to give.
  assign evt_load = (state == S_SCAN) && adv &&
                    ((sel.hit && pend_valid) ||
                     (end_tok && (pend_valid || op == OP_ADD || op == OP_CANCEL)));

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      launch     <= 1'b0;
      pend_valid <= 1'b0;
      evt_valid  <= 1'b0;
      now        <= '0;
    end else begin
      // Hold the event beat until taken; drop it unless a new one loads.
      if (evt_load) begin
        evt_valid <= 1'b1;
      end else if (evt_valid && !evt_stall) begin
        evt_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            launch <= 1'b1;
            state  <= S_SCAN;
            // A tick advances time before any slot is checked.
            if (cmd.opcode == OP_TICK) begin
              now <= now + TIME_W'(1);
            end
          end
        end
        S_SCAN: begin
          if (adv) begin
            launch <= 1'b0;
            if (sel.hit) begin
              pend_valid <= 1'b1;
            end
            if (end_tok) begin
              pend_valid <= 1'b0;
              state      <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      op       <= cmd.opcode;
      period   <= (cmd.interval_ticks == '0) ? TIME_W'(1) : cmd.interval_ticks;
      periodic <= cmd.periodic;
      handle   <= cmd.handle;
    end
    if (state == S_SCAN && adv) begin
      if (sel.hit) begin
        if (pend_valid) begin
          evt_q <= to_evt(pend, 1'b0);
        end
        pend <= sel;
      end
      if (end_tok) begin
        if (pend_valid) begin
          evt_q <= to_evt(pend, 1'b1);
        end else begin
          // Answer with a full flag or an idle cancel when no cell reported.
          case (op)
            OP_ADD:    evt_q <= '{kind: KIND_ADD, slot: '0, ok: 1'b0,
                                  was_periodic: 1'b0, last: 1'b1};
            OP_CANCEL: evt_q <= '{kind: KIND_CANCEL, slot: handle, ok: 1'b0,
                                  was_periodic: 1'b0, last: 1'b1};
            default:   evt_q <= evt_q;
          endcase
        end
      end
    end
  end

  `MTS_ASSERT_ALWAYS(a_one_token, $onehot0(tok_vec), "more than one token in the slot chain")
  `MTS_ASSERT_ALWAYS(a_idle_no_pend, (state != S_IDLE) || !pend_valid, "held firing while idle")
  `MTS_ASSERT_ALWAYS(a_idle_no_token, (state != S_IDLE) || (tok_vec == '0), "token while idle")
  `MTS_ASSERT_NEXT(a_close_out, (state == S_SCAN) && adv && end_tok, state == S_IDLE, "scan did not close")

endmodule

`default_nettype wire
